@@ rtl/afpg_pkg.sv @@
package afpg_pkg;

    // Field widths.
    localparam int SAMPLE_BITS = 16;
    localparam int RAMP_BITS   = 24;
    localparam int TOTAL_BITS  = 32;
    localparam int MODE_BITS   = 2;
    localparam int CHAN_BITS   = 2;

    // Serial multiply/divide sizing.
    localparam int PROD_BITS = SAMPLE_BITS + RAMP_BITS;
    localparam int STEP_BITS = $clog2(SAMPLE_BITS);

    // APB register file.
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 4;
    localparam int REG_BITS  = 2;

    localparam logic [REG_BITS-1:0] REG_MODE  = 2'd0;
    localparam logic [REG_BITS-1:0] REG_RAMP  = 2'd1;
    localparam logic [REG_BITS-1:0] REG_CHAN  = 2'd2;
    localparam logic [REG_BITS-1:0] REG_TOTAL = 2'd3;

    // Effect modes.
    localparam logic [MODE_BITS-1:0] MODE_FADE_IN  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_FADE_OUT = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_PAN      = 2'd2;

    // Channel layout.
    localparam logic [CHAN_BITS-1:0] CHAN_MONO   = 2'd1;
    localparam logic [CHAN_BITS-1:0] CHAN_STEREO = 2'd2;

endpackage

@@ rtl/afpg_muldiv.sv @@
// Bit-serial unit: quot = floor(mag * idx / ramp), with idx <= ramp.
// One multiplier bit per cycle, then one quotient bit per cycle.
module afpg_muldiv
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [afpg_pkg::SAMPLE_BITS-1:0]   mag,
    input  logic [afpg_pkg::RAMP_BITS-1:0]     idx,
    input  logic [afpg_pkg::RAMP_BITS-1:0]     ramp,
    output logic                               done,
    output logic [afpg_pkg::SAMPLE_BITS-1:0]   quot
);

    localparam int SB = afpg_pkg::SAMPLE_BITS;
    localparam int RB = afpg_pkg::RAMP_BITS;
    localparam int PB = afpg_pkg::PROD_BITS;
    localparam int CB = afpg_pkg::STEP_BITS;
    localparam logic [CB-1:0] STEP_LAST = CB'(SB - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_t;

    state_t          state_reg, state_next;
    logic [CB-1:0]   cnt_reg, cnt_next;
    logic [SB-1:0]   mag_reg, mag_next;
    logic [RB-1:0]   idx_reg, idx_next;
    logic [PB-1:0]   acc_reg, acc_next;
    logic            done_reg, done_next;

    logic [RB:0]     trial;
    logic [RB:0]     diff;
    logic            ge;

    // Restoring division step on the upper part of the accumulator.
    assign trial = {acc_reg[PB-1:SB], acc_reg[SB-1]};
    assign diff  = trial - {1'b0, ramp};
    assign ge    = (trial >= {1'b0, ramp});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mag_next   = mag;
                    idx_next   = idx;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // Shift-add, multiplier bits taken MSB first.
                acc_next = {acc_reg[PB-2:0], 1'b0}
                         + (mag_reg[SB-1] ? PB'(idx_reg) : PB'(0));
                mag_next = {mag_reg[SB-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Remainder stays below ramp; quotient bits shift in at the bottom.
                acc_next = {(ge ? diff[RB-1:0] : trial[RB-1:0]), acc_reg[SB-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            mag_reg   <= '0;
            idx_reg   <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            mag_reg   <= mag_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
        end
    end

    assign done = done_reg;
    assign quot = acc_reg[SB-1:0];

endmodule

@@ rtl/audio_fade_pan_gain_ramp.sv @@
// Channel   Signals                                   Beat
// -------   ---------------------------------------   ---------------------------
// config    psel penable pwrite paddr pwdata prdata   write: psel&penable&pwrite
// input     in_valid in_ready sample_in               in_valid & in_ready
// output    out_valid out_ready sample_out            out_valid & out_ready
//
// A scaled sample takes 16 multiply steps and 16 divide steps in the bit-serial unit,
// then passes through res_reg into the output register once that register is free.
// A sample that passes unchanged skips the unit and goes through res_reg the same way.
// One sample is in flight at a time, so no input beat is taken until the last one is out;
// a finished result waits in the output register while the next input beat is taken.
// Any register write restarts the stream; input is held off while restart_reg is set.
module audio_fade_pan_gain_ramp
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [afpg_pkg::ADDR_BITS-1:0]          paddr,
    input  logic [afpg_pkg::DATA_BITS-1:0]          pwdata,
    output logic [afpg_pkg::DATA_BITS-1:0]          prdata,
    output logic                                    pready,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [afpg_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [afpg_pkg::SAMPLE_BITS-1:0] sample_out
);

    localparam int SB = afpg_pkg::SAMPLE_BITS;
    localparam int RB = afpg_pkg::RAMP_BITS;
    localparam int TB = afpg_pkg::TOTAL_BITS;
    localparam int MB = afpg_pkg::MODE_BITS;
    localparam int HB = afpg_pkg::CHAN_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_HOLD} state_t;

    state_t          state_reg, state_next;
    logic [MB-1:0]   mode_reg, mode_next;
    logic [RB-1:0]   ramp_reg, ramp_next;
    logic [HB-1:0]   chan_reg, chan_next;
    logic [TB-1:0]   total_reg, total_next;
    logic            restart_reg, restart_next;
    logic [RB:0]     rise_reg, rise_next;
    logic [RB-1:0]   fall_reg, fall_next;
    logic [TB-1:0]   skip_reg, skip_next;
    logic            pos_reg, pos_next;
    logic            neg_reg, neg_next;
    logic [SB-1:0]   res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    logic [SB-1:0]   sample_out_reg, sample_out_next;

    logic            cfg_wr;
    logic            in_beat;
    logic            stereo;
    logic            right;
    logic            frame_end;
    logic            on;
    logic            scale;
    logic [RB-1:0]   gain_idx;
    logic [SB-1:0]   mag;
    logic            md_start;
    logic            md_done;
    logic [SB-1:0]   md_quot;
    logic [TB-1:0]   ramp_wide;

    assign cfg_wr   = psel && penable && pwrite;
    assign in_ready = (state_reg == ST_IDLE) && !restart_reg;
    assign in_beat  = in_valid && in_ready;

    // Frame position and effect enable.
    assign stereo    = (chan_reg == afpg_pkg::CHAN_STEREO);
    assign right     = stereo && pos_reg;
    assign frame_end = !stereo || right;
    assign on        = (ramp_reg != '0);
    assign ramp_wide = TB'(ramp_reg);

    // Sign and magnitude of the incoming sample.
    assign mag = sample_in[SB-1] ? (~sample_in + 1'b1) : sample_in;

    assign md_start = in_beat && scale;

    // Gain selection for the current sample.
    always_comb
    begin
        scale    = 1'b0;
        gain_idx = fall_reg;
        case (mode_reg)
            afpg_pkg::MODE_FADE_IN:
            begin
                scale    = on && (rise_reg <= {1'b0, ramp_reg});
                gain_idx = rise_reg[RB-1:0];
            end
            afpg_pkg::MODE_FADE_OUT:
            begin
                scale    = on && (skip_reg == '0);
                gain_idx = fall_reg;
            end
            afpg_pkg::MODE_PAN:
            begin
                scale    = on;
                gain_idx = right ? rise_reg[RB-1:0] : fall_reg;
            end
            default:
            begin
                scale = 1'b0;
            end
        endcase
    end

    // Register file, stream state and sample sequencing.
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        ramp_next       = ramp_reg;
        chan_next       = chan_reg;
        total_next      = total_reg;
        restart_next    = 1'b0;
        rise_next       = rise_reg;
        fall_next       = fall_reg;
        skip_next       = skip_reg;
        pos_next        = pos_reg;
        neg_next        = neg_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;

        if (cfg_wr)
        begin
            restart_next = 1'b1;
            case (paddr[3:2])
                afpg_pkg::REG_MODE:  mode_next  = pwdata[MB-1:0];
                afpg_pkg::REG_RAMP:  ramp_next  = pwdata[RB-1:0];
                afpg_pkg::REG_CHAN:  chan_next  = pwdata[HB-1:0];
                afpg_pkg::REG_TOTAL: total_next = pwdata[TB-1:0];
                default:             restart_next = 1'b0;
            endcase
        end

        // Stream restart uses the registers as just written.
        if (restart_reg)
        begin
            rise_next = '0;
            fall_next = on ? (ramp_reg - 1'b1) : '0;
            skip_next = (total_reg > ramp_wide) ? (total_reg - ramp_wide) : '0;
            pos_next  = 1'b0;
        end

        // Index stepping on each input beat.
        if (in_beat)
        begin
            case (mode_reg)
                afpg_pkg::MODE_FADE_IN:
                begin
                    if (scale && frame_end)
                    begin
                        rise_next = rise_reg + 1'b1;
                    end
                end
                afpg_pkg::MODE_FADE_OUT:
                begin
                    if (scale && frame_end && (fall_reg != '0))
                    begin
                        fall_next = fall_reg - 1'b1;
                    end
                end
                afpg_pkg::MODE_PAN:
                begin
                    if (on && right && (rise_reg < {1'b0, ramp_reg}))
                    begin
                        rise_next = rise_reg + 1'b1;
                    end
                    if (on && !right && (fall_reg != '0))
                    begin
                        fall_next = fall_reg - 1'b1;
                    end
                end
                default:
                begin
                    rise_next = rise_reg;
                end
            endcase
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - 1'b1;
            end
            pos_next = stereo ? !pos_reg : 1'b0;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    neg_next = sample_in[SB-1];
                    res_next = sample_in;
                    state_next = scale ? ST_BUSY : ST_HOLD;
                end
            end
            ST_BUSY:
            begin
                if (md_done)
                begin
                    res_next   = neg_reg ? (~md_quot + 1'b1) : md_quot;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = res_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= afpg_pkg::MODE_FADE_IN;
            ramp_reg       <= '0;
            chan_reg       <= afpg_pkg::CHAN_MONO;
            total_reg      <= '0;
            restart_reg    <= 1'b0;
            rise_reg       <= '0;
            fall_reg       <= '0;
            skip_reg       <= '0;
            pos_reg        <= 1'b0;
            neg_reg        <= 1'b0;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
            sample_out_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            ramp_reg       <= ramp_next;
            chan_reg       <= chan_next;
            total_reg      <= total_next;
            restart_reg    <= restart_next;
            rise_reg       <= rise_next;
            fall_reg       <= fall_next;
            skip_reg       <= skip_next;
            pos_reg        <= pos_next;
            neg_reg        <= neg_next;
            res_reg        <= res_next;
            out_valid_reg  <= out_valid_next;
            sample_out_reg <= sample_out_next;
        end
    end

    // Serial scaling unit.
    afpg_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .mag   (mag),
        .idx   (gain_idx),
        .ramp  (ramp_reg),
        .done  (md_done),
        .quot  (md_quot)
    );

    // Register readback.
    always_comb
    begin
        case (paddr[3:2])
            afpg_pkg::REG_MODE:  prdata = afpg_pkg::DATA_BITS'(mode_reg);
            afpg_pkg::REG_RAMP:  prdata = afpg_pkg::DATA_BITS'(ramp_reg);
            afpg_pkg::REG_CHAN:  prdata = afpg_pkg::DATA_BITS'(chan_reg);
            afpg_pkg::REG_TOTAL: prdata = afpg_pkg::DATA_BITS'(total_reg);
            default:             prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

`ifndef NO_ASSERTIONS
    // A register write holds off input for the restart cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !in_ready)
        else $error("input taken during stream restart");

    // Only one sample is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ready)
        else $error("second sample accepted while one is in flight");

    // The serial unit reports completion only while a sample waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == ST_BUSY))
        else $error("scaling unit finished with no sample pending");

    // The falling index never exceeds ramp minus one once the stream is set up.
    assert property (@(posedge clk) disable iff (!rst_n)
        !restart_reg |-> ((fall_reg < ramp_reg) || (fall_reg == '0)))
        else $error("falling index out of range");

    // The rising index stops one past the ramp length.
    assert property (@(posedge clk) disable iff (!rst_n)
        !restart_reg |-> (rise_reg <= ({1'b0, ramp_reg} + 1'b1)))
        else $error("rising index out of range");
`endif

endmodule
